// ===== design/pae_pkg.sv =====
`default_nettype none
package pae_pkg;

	localparam int MAX_STEPS_DEF = 4096;
	localparam int MAX_VARS_DEF  = 4;
	localparam int MAX_LAGS_DEF  = 64;

	localparam int SAMPLE_W = 32;
	localparam int VAR_W    = 2;
	localparam int LAG_W    = 13;
	localparam int ACF_W    = 16;
	localparam int CFG_IW   = 2;
	localparam int CFG_DW   = 12;
	localparam int LFIRST_W = 12;
	localparam int LCNT_W   = 7;
	localparam int NVREG_W  = 3;

	localparam int QUEUE_DEPTH = 4;

	localparam int DIV_NW = 80;
	localparam int DIV_DW = 64;
	localparam int FRAC_SHIFT = 15;

	typedef enum logic [CFG_IW-1:0] {
		REG_NUM_VARS  = 2'd0,
		REG_LAG_FIRST = 2'd1,
		REG_LAG_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [LFIRST_W-1:0] lag_first;
		logic [LCNT_W-1:0]   lag_cnt;
	} lag_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN_RUN,
		ST_MEAN_DRAIN,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_POOL_RUN,
		ST_POOL_DRAIN,
		ST_L0_GO,
		ST_L0_WAIT,
		ST_LAG_SETUP,
		ST_COV_GO,
		ST_COV_WAIT,
		ST_RAT_GO,
		ST_RAT_WAIT,
		ST_EMIT
	} back_state_t;

endpackage
`default_nettype wire

// ===== design/pae_if.sv =====
`default_nettype none
interface pae_in_if;
	import pae_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [VAR_W-1:0]           var_index;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;
	modport source (output valid, var_index, sample, last_sample, input ready);
	modport sink (input valid, var_index, sample, last_sample, output ready);
endinterface

interface pae_out_if;
	import pae_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [LAG_W-1:0]        lag;
	logic signed [ACF_W-1:0] acf_value;
	logic                    zero_variance;
	logic                    last_lag;
	modport source (output valid, lag, acf_value, zero_variance, last_lag, input ready);
	modport sink (input valid, lag, acf_value, zero_variance, last_lag, output ready);
endinterface

interface pae_cfg_if;
	import pae_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/pae_div.sv =====
`default_nettype none
module pae_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pae_pkg::DIV_NW-1:0] dividend,
	input  wire logic [pae_pkg::DIV_DW-1:0] divisor,
	output logic                            done,
	output logic [pae_pkg::DIV_NW-1:0]      quotient
);
	import pae_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] dsor_q;
	logic [DIV_DW:0]   trial;
	logic              ge;

	assign trial = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
	assign ge    = trial >= {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dsor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, dsor_q} : trial;
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== design/pae_front.sv =====
`default_nettype none
module pae_front #(
	parameter int MAX_STEPS = pae_pkg::MAX_STEPS_DEF,
	parameter int MAX_VARS  = pae_pkg::MAX_VARS_DEF,
	parameter int MAX_LAGS  = pae_pkg::MAX_LAGS_DEF,
	localparam int AW = $clog2(MAX_STEPS * MAX_VARS),
	localparam int SW = $clog2(MAX_STEPS + 1),
	localparam int VW = $clog2(MAX_VARS + 1),
	localparam int QW = 2 + AW + SW + pae_pkg::SAMPLE_W
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	pae_in_if.sink            samples,
	pae_cfg_if.sink           cfg,
	output logic              push,
	output logic [QW-1:0]     push_data,
	input  wire logic         full,
	output logic [VW-1:0]     nv,
	output pae_pkg::lag_cfg_t lag_cfg
);
	import pae_pkg::*;

	logic [NVREG_W-1:0]  num_vars_q;
	logic [LFIRST_W-1:0] lag_first_q;
	logic [LCNT_W-1:0]   lag_count_q;
	logic [SW-1:0]       cnt_q;
	logic                acc;
	logic                store;
	logic                complete;
	logic [SW-1:0]       n_next;
	logic [AW-1:0]       addr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q  <= NVREG_W'(1);
			lag_first_q <= LFIRST_W'(1);
			lag_count_q <= LCNT_W'(20);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_NUM_VARS:  num_vars_q  <= cfg.data[NVREG_W-1:0];
				REG_LAG_FIRST: lag_first_q <= cfg.data[LFIRST_W-1:0];
				REG_LAG_COUNT: lag_count_q <= cfg.data[LCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (num_vars_q == '0)
			nv = VW'(1);
		else if (32'(num_vars_q) > MAX_VARS)
			nv = VW'(MAX_VARS);
		else
			nv = VW'(num_vars_q);
		if (lag_count_q == '0)
			lag_cfg.lag_cnt = LCNT_W'(1);
		else if (32'(lag_count_q) > MAX_LAGS)
			lag_cfg.lag_cnt = LCNT_W'(MAX_LAGS);
		else
			lag_cfg.lag_cnt = lag_count_q;
		lag_cfg.lag_first = lag_first_q;
	end

	assign samples.ready = !full;
	assign acc      = samples.valid && !full;
	assign store    = (32'(samples.var_index) < 32'(nv)) && (32'(cnt_q) < MAX_STEPS);
	assign complete = store && (32'(samples.var_index) == 32'(nv) - 1);
	assign n_next   = cnt_q + SW'(complete);
	assign addr     = AW'(cnt_q) * AW'(MAX_VARS) + AW'(samples.var_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (acc)
			cnt_q <= samples.last_sample ? '0 : n_next;
	end

	assign push      = acc && (store || samples.last_sample);
	assign push_data = {store, samples.last_sample, addr, n_next, samples.sample};
endmodule
`default_nettype wire

// ===== design/pae_queue.sv =====
`default_nettype none
module pae_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pae_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	output logic                  valid,
	output logic [WIDTH-1:0]      data,
	input  wire logic             ready
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             pop;

	assign full  = cnt_q == CW'(DEPTH);
	assign valid = cnt_q != '0;
	assign data  = mem_q[rd_q];
	assign pop   = valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end
endmodule
`default_nettype wire

// ===== design/pae_back.sv =====
`default_nettype none
module pae_back #(
	parameter int MAX_STEPS = pae_pkg::MAX_STEPS_DEF,
	parameter int MAX_VARS  = pae_pkg::MAX_VARS_DEF,
	localparam int AW = $clog2(MAX_STEPS * MAX_VARS),
	localparam int SW = $clog2(MAX_STEPS + 1),
	localparam int VW = $clog2(MAX_VARS + 1),
	localparam int QW = 2 + AW + SW + pae_pkg::SAMPLE_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire logic [QW-1:0]     q_data,
	output logic                   q_ready,
	input  wire logic [VW-1:0]     nv,
	input  wire pae_pkg::lag_cfg_t lag_cfg,
	pae_out_if.source              acf
);
	import pae_pkg::*;

	localparam int DEPTH = MAX_STEPS * MAX_VARS;
	localparam int VIW   = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
	localparam int SUMW  = 33 + $clog2(MAX_STEPS);

	back_state_t state_q, state_d;

	logic signed [SAMPLE_W-1:0] mem [DEPTH];
	logic signed [SAMPLE_W-1:0] mean_q [MAX_VARS];

	logic                       e_store;
	logic                       e_last;
	logic [AW-1:0]              e_addr;
	logic [SW-1:0]              e_n;
	logic signed [SAMPLE_W-1:0] e_sample;

	logic [SW-1:0]   n_q, j_q, jb_q, start_q, len_q;
	logic [VIW-1:0]  v_q, v_s1;
	logic            vld_s1, vld_s2, vld_s3;
	logic            mean_mode_q, lag0_ph_q, zero_q, neg_q;
	logic signed [SAMPLE_W-1:0] rd_a_s1, rd_b_s1, dev_a_s2, dev_b_s2;
	logic signed [63:0] prod_s3, acc_q, term;
	logic signed [SUMW-1:0] sum_q;
	logic [63:0]     lag0_q, qmag_q;
	logic [LCNT_W-1:0] k_q;
	logic [LAG_W-1:0]  lag_q;
	logic signed [ACF_W-1:0] acf_q;

	logic            out_v_q;
	logic [LAG_W-1:0] out_lag_q;
	logic signed [ACF_W-1:0] out_acf_q;
	logic            out_zero_q, out_last_q;

	logic [AW-1:0]   addr_a, addr_b;
	logic            issue, last_j, last_v, drain_done, live, emit_ok, last_k, pop;
	logic            div_start, div_done;
	logic [DIV_NW-1:0] div_nd, div_q;
	logic [DIV_DW-1:0] div_dd;
	logic [SUMW-1:0] sum_mag;
	logic [63:0]     acc_mag;
	logic signed [ACF_W-1:0] ratio;
	logic [16:0]     rnd;

	function automatic logic signed [SAMPLE_W-1:0] sat_dev(
		input logic signed [SAMPLE_W-1:0] a, input logic signed [SAMPLE_W-1:0] b);
		logic signed [SAMPLE_W:0] d;
		d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
		if (d[SAMPLE_W] != d[SAMPLE_W-1])
			return d[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
		return d[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [63:0] sat_add(
		input logic signed [63:0] a, input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	assign e_sample = q_data[SAMPLE_W-1:0];
	assign e_n      = q_data[SAMPLE_W +: SW];
	assign e_addr   = q_data[SAMPLE_W+SW +: AW];
	assign e_last   = q_data[SAMPLE_W+SW+AW];
	assign e_store  = q_data[SAMPLE_W+SW+AW+1];

	assign addr_a     = AW'(j_q) * AW'(MAX_VARS) + AW'(v_q);
	assign addr_b     = AW'(jb_q) * AW'(MAX_VARS) + AW'(v_q);
	assign last_j     = j_q == len_q - SW'(1);
	assign last_v     = 32'(v_q) == 32'(nv) - 1;
	assign drain_done = !vld_s1 && !vld_s2 && !vld_s3;
	assign live       = !zero_q && (32'(lag_q) < 32'(n_q));
	assign emit_ok    = !out_v_q || acf.ready;
	assign last_k     = k_q == lag_cfg.lag_cnt - LCNT_W'(1);
	assign pop        = q_valid && q_ready;
	assign term       = prod_s3 >>> 16;
	assign sum_mag    = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
	assign acc_mag    = acc_q[63] ? ~acc_q + 64'd1 : acc_q;
	assign rnd        = ({1'b0, div_q[15:0]} + 17'd1) >> 1;

	always_comb begin
		if (div_q[DIV_NW-1:16] != '0)
			ratio = neg_q ? {1'b1, {(ACF_W-1){1'b0}}} : {1'b0, {(ACF_W-1){1'b1}}};
		else if (neg_q)
			ratio = ACF_W'(-rnd);
		else if (rnd[16] || rnd[15])
			ratio = {1'b0, {(ACF_W-1){1'b1}}};
		else
			ratio = rnd[15:0];
	end

	always_comb begin
		state_d   = state_q;
		q_ready   = 1'b0;
		issue     = 1'b0;
		div_start = 1'b0;
		div_nd    = '0;
		div_dd    = '0;
		unique case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid && e_last)
					state_d = (e_n == '0) ? ST_LAG_SETUP : ST_MEAN_RUN;
			end
			ST_MEAN_RUN: begin
				issue = 1'b1;
				if (last_j)
					state_d = ST_MEAN_DRAIN;
			end
			ST_MEAN_DRAIN: if (drain_done) state_d = ST_MEAN_GO;
			ST_MEAN_GO: begin
				div_start = 1'b1;
				div_nd    = DIV_NW'(sum_mag);
				div_dd    = DIV_DW'(n_q);
				state_d   = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: if (div_done) state_d = last_v ? ST_POOL_RUN : ST_MEAN_RUN;
			ST_POOL_RUN: begin
				issue = 1'b1;
				if (last_j && last_v)
					state_d = ST_POOL_DRAIN;
			end
			ST_POOL_DRAIN: if (drain_done) state_d = lag0_ph_q ? ST_L0_GO : ST_COV_GO;
			ST_L0_GO: begin
				div_start = 1'b1;
				div_nd    = DIV_NW'(acc_mag);
				div_dd    = DIV_DW'(n_q);
				state_d   = ST_L0_WAIT;
			end
			ST_L0_WAIT: if (div_done) state_d = ST_LAG_SETUP;
			ST_LAG_SETUP: state_d = live ? ST_POOL_RUN : ST_EMIT;
			ST_COV_GO: begin
				div_start = 1'b1;
				div_nd    = DIV_NW'(acc_mag);
				div_dd    = DIV_DW'(len_q);
				state_d   = ST_COV_WAIT;
			end
			ST_COV_WAIT: if (div_done) state_d = ST_RAT_GO;
			ST_RAT_GO: begin
				div_start = 1'b1;
				div_nd    = DIV_NW'({qmag_q, FRAC_SHIFT'(0)});
				div_dd    = lag0_q;
				state_d   = ST_RAT_WAIT;
			end
			ST_RAT_WAIT: if (div_done) state_d = ST_EMIT;
			ST_EMIT: if (emit_ok) state_d = last_k ? ST_IDLE : ST_LAG_SETUP;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	pae_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_nd),
		.divisor  (div_dd),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (pop && e_store)
			mem[e_addr] <= e_sample;
		rd_a_s1 <= mem[addr_a];
		rd_b_s1 <= mem[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (state_q == ST_EMIT && emit_ok)
				out_v_q <= 1'b1;
			else if (acf.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		v_s1     <= v_q;
		dev_a_s2 <= sat_dev(rd_a_s1, mean_q[v_s1]);
		dev_b_s2 <= sat_dev(rd_b_s1, mean_q[v_s1]);
		prod_s3  <= dev_a_s2 * dev_b_s2;
		if (vld_s1 && mean_mode_q)
			sum_q <= sum_q + SUMW'(rd_a_s1);
		if (vld_s3 && !mean_mode_q)
			acc_q <= sat_add(acc_q, term);

		if (issue) begin
			if (last_j) begin
				j_q  <= '0;
				jb_q <= start_q;
				if (state_q == ST_POOL_RUN)
					v_q <= v_q + VIW'(1);
			end else begin
				j_q  <= j_q + SW'(1);
				jb_q <= jb_q + SW'(1);
			end
		end

		unique case (state_q)
			ST_IDLE: begin
				n_q         <= e_n;
				v_q         <= '0;
				j_q         <= '0;
				jb_q        <= '0;
				start_q     <= '0;
				len_q       <= e_n;
				sum_q       <= '0;
				mean_mode_q <= 1'b1;
				lag0_ph_q   <= 1'b1;
				zero_q      <= 1'b1;
				lag0_q      <= '0;
				k_q         <= '0;
				lag_q       <= LAG_W'(lag_cfg.lag_first);
			end
			ST_MEAN_WAIT: if (div_done) begin
				mean_q[v_q] <= sum_q[SUMW-1] ? -SAMPLE_W'(div_q) : SAMPLE_W'(div_q);
				j_q         <= '0;
				jb_q        <= '0;
				sum_q       <= '0;
				acc_q       <= '0;
				if (last_v) begin
					v_q         <= '0;
					mean_mode_q <= 1'b0;
				end else begin
					v_q <= v_q + VIW'(1);
				end
			end
			ST_L0_WAIT: if (div_done) begin
				lag0_q <= div_q[63:0];
				zero_q <= div_q[63:0] == '0;
			end
			ST_LAG_SETUP: begin
				lag0_ph_q   <= 1'b0;
				mean_mode_q <= 1'b0;
				acf_q       <= '0;
				v_q         <= '0;
				j_q         <= '0;
				jb_q        <= SW'(lag_q);
				start_q     <= SW'(lag_q);
				len_q       <= n_q - SW'(lag_q);
				acc_q       <= '0;
			end
			ST_COV_WAIT: if (div_done) begin
				qmag_q <= div_q[63:0];
				neg_q  <= acc_q[63];
			end
			ST_RAT_WAIT: if (div_done) acf_q <= ratio;
			ST_EMIT: if (emit_ok) begin
				out_lag_q  <= lag_q;
				out_acf_q  <= acf_q;
				out_zero_q <= zero_q;
				out_last_q <= last_k;
				k_q        <= k_q + LCNT_W'(1);
				lag_q      <= lag_q + LAG_W'(1);
			end
			default: ;
		endcase
	end

	assign acf.valid         = out_v_q;
	assign acf.lag           = out_lag_q;
	assign acf.acf_value     = out_acf_q;
	assign acf.zero_variance = out_zero_q;
	assign acf.last_lag      = out_last_q;
endmodule
`default_nettype wire

// ===== design/pooled_autocorrelation_engine_top.sv =====
`default_nettype none
// Loading: one sample word per cycle while the four-entry queue has room.
// Compute after the last word, while new sample words wait in the queue: a summing pass and
// a divide for each variable's mean, a pooled pass and a divide for lag zero, then per lag a
// pooled pass and two divides (covariance, then ratio), or neither for a lag at or past N.
// Results leave through a one-word output register; the next lag waits for it to free.
// Reset clears control state and loads the configuration defaults; the sample store and data registers are not cleared.
module pooled_autocorrelation_engine_top #(
	parameter int MAX_STEPS = pae_pkg::MAX_STEPS_DEF,
	parameter int MAX_VARS  = pae_pkg::MAX_VARS_DEF,
	parameter int MAX_LAGS  = pae_pkg::MAX_LAGS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pae_in_if.sink    samples,
	pae_out_if.source acf,
	pae_cfg_if.sink   cfg
);
	import pae_pkg::*;

	localparam int AW = $clog2(MAX_STEPS * MAX_VARS);
	localparam int SW = $clog2(MAX_STEPS + 1);
	localparam int VW = $clog2(MAX_VARS + 1);
	localparam int QW = 2 + AW + SW + SAMPLE_W;

	logic          push, full, q_valid, q_ready;
	logic [QW-1:0] push_data, q_data;
	logic [VW-1:0] nv;
	lag_cfg_t      lag_cfg;

	pae_front #(
		.MAX_STEPS (MAX_STEPS),
		.MAX_VARS  (MAX_VARS),
		.MAX_LAGS  (MAX_LAGS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.cfg       (cfg),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.nv        (nv),
		.lag_cfg   (lag_cfg)
	);

	pae_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.valid     (q_valid),
		.data      (q_data),
		.ready     (q_ready)
	);

	pae_back #(
		.MAX_STEPS (MAX_STEPS),
		.MAX_VARS  (MAX_VARS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_ready (q_ready),
		.nv      (nv),
		.lag_cfg (lag_cfg),
		.acf     (acf)
	);
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import pae_pkg::*;

	localparam int STORE_N = MAX_STEPS_DEF * MAX_VARS_DEF;
	localparam longint CYCLE_LIMIT = 40000000;

	typedef struct {
		logic [LAG_W-1:0] lag;
		logic [ACF_W-1:0] acf_value;
		logic             zero_variance;
		logic             last_lag;
	} acf_word_t;

	typedef struct {
		bit                is_cfg;
		cfg_reg_t          idx;
		logic [CFG_DW-1:0] data;
		logic [VAR_W-1:0]  vi;
		logic [31:0]       smp;
		bit                last;
		bit                zero_run;
	} row_t;

	logic clk;
	logic arst_n;
	pae_in_if  samples();
	pae_out_if acf();
	pae_cfg_if cfg();

	pooled_autocorrelation_engine_top u_top (
		.clk(clk), .arst_n(arst_n), .samples(samples), .acf(acf), .cfg(cfg)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	int store_mem [STORE_N];
	longint mean_sum [MAX_VARS_DEF];
	int mean_val [MAX_VARS_DEF];
	int unsigned step_cnt;
	logic [NVREG_W-1:0] nv_reg;
	logic [LFIRST_W-1:0] lf_reg;
	logic [LCNT_W-1:0] lc_reg;
	acf_word_t acf_expected [$];

	int errors;
	int items_sent;
	int send_pct;
	int stall_pct;
	longint cycles;

	function automatic int unsigned eff_vars();
		if (nv_reg == 0) return 1;
		if (nv_reg > MAX_VARS_DEF) return MAX_VARS_DEF;
		return nv_reg;
	endfunction

	function automatic int unsigned eff_lags();
		if (lc_reg == 0) return 1;
		if (lc_reg > MAX_LAGS_DEF) return MAX_LAGS_DEF;
		return lc_reg;
	endfunction

	function automatic int deviation(int unsigned j, int unsigned v);
		longint d;
		d = longint'(store_mem[j * MAX_VARS_DEF + v]) - longint'(mean_val[v]);
		if (d > 64'sd2147483647) d = 64'sd2147483647;
		if (d < -64'sd2147483648) d = -64'sd2147483648;
		return int'(d);
	endfunction

	function automatic longint pooled_cov(int unsigned nv, int unsigned n, int unsigned lag);
		longint acc, p, s;
		acc = 0;
		for (int unsigned v = 0; v < nv; v++)
			for (int unsigned j = 0; j + lag < n; j++) begin
				p = longint'(deviation(j, v)) * longint'(deviation(j + lag, v));
				p = p >>> 16;
				s = acc + p;
				if (acc[63] == p[63] && s[63] != acc[63])
					s = p[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
				acc = s;
			end
		return acc;
	endfunction

	function automatic logic [15:0] ratio_q14(longint cov, longint cov0);
		bit neg;
		logic [63:0] a, b, q, r, m;
		longint s;
		neg = cov < 0;
		a = neg ? 64'd0 - cov : cov;
		b = cov0;
		q = a / b;
		r = a % b;
		if (q >= 2) return neg ? 16'h8000 : 16'h7FFF;
		m = q;
		for (int i = 0; i < 15; i++) begin
			r = r << 1;
			m = m << 1;
			if (r >= b) begin
				r = r - b;
				m[0] = 1'b1;
			end
		end
		m = (m + 1) >> 1;
		s = neg ? -longint'(m) : longint'(m);
		if (s > 32767) s = 32767;
		if (s < -32768) s = -32768;
		return s[15:0];
	endfunction

	function automatic void predict_word(logic [1:0] vi, logic [31:0] smp, bit last, bit zero_run);
		int unsigned nv, n, cnt, lag;
		longint cov0, acc;
		bit zero;
		acf_word_t w;
		nv = eff_vars();
		if (vi < nv && step_cnt < MAX_STEPS_DEF) begin
			store_mem[step_cnt * MAX_VARS_DEF + vi] = smp;
			if (vi == nv - 1) step_cnt++;
		end
		if (!last) return;
		n = step_cnt;
		for (int unsigned v = 0; v < nv; v++) begin
			mean_sum[v] = 0;
			for (int unsigned j = 0; j < n; j++)
				mean_sum[v] += longint'(store_mem[j * MAX_VARS_DEF + v]);
			mean_val[v] = (n == 0) ? 0 : int'(mean_sum[v] / longint'(n));
		end
		cov0 = (n == 0) ? 0 : pooled_cov(nv, n, 0) / longint'(n);
		zero = cov0 == 0;
		cnt = eff_lags();
		for (int unsigned k = 0; k < cnt; k++) begin
			lag = lf_reg + k;
			w.lag = LAG_W'(lag);
			w.acf_value = 0;
			if (!zero && lag < n) begin
				acc = pooled_cov(nv, n, lag);
				w.acf_value = ratio_q14(acc / longint'(n - lag), cov0);
			end
			w.zero_variance = zero;
			w.last_lag = (k == cnt - 1);
			if (zero_run) begin
				w.acf_value = 0;
				w.zero_variance = 1'b1;
			end
			acf_expected.push_back(w);
		end
		step_cnt = 0;
	endfunction

	task automatic send_sample(logic [1:0] vi, logic [31:0] smp, bit last, bit zero_run);
		if ($urandom_range(99) < send_pct) begin
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.var_index <= vi;
		samples.sample <= smp;
		samples.last_sample <= last;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		predict_word(vi, smp, last, zero_run);
		items_sent++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DW-1:0] data);
		samples.valid <= 1'b0;
		@(posedge clk);
		while (acf_expected.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_NUM_VARS: nv_reg = data[NVREG_W-1:0];
			REG_LAG_FIRST: lf_reg = data[LFIRST_W-1:0];
			REG_LAG_COUNT: lc_reg = data[LCNT_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_value(int base);
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
			2: return base;
			default: return base + int'($urandom_range(2 * 65536)) - 65536;
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acf.ready <= 1'b0;
		end else begin
			acf.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		acf_word_t e;
		if (arst_n && acf.valid && acf.ready) begin
			if (acf_expected.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: lag %0d acf %0d", acf.lag, acf.acf_value);
			end else begin
				e = acf_expected.pop_front();
				if (acf.lag !== e.lag || acf.acf_value !== e.acf_value
						|| acf.zero_variance !== e.zero_variance || acf.last_lag !== e.last_lag) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp lag %0d acf %0d zv %0b ll %0b, got lag %0d acf %0d zv %0b ll %0b",
							e.lag, $signed(e.acf_value), e.zero_variance, e.last_lag,
							acf.lag, $signed(acf.acf_value), acf.zero_variance, acf.last_lag);
				end
			end
		end
	end

	initial begin
		row_t rows [$];
		int unsigned steps, nv;
		int base;
		bit flat;
		logic [1:0] vi;
		errors = 0;
		items_sent = 0;
		cycles = 0;
		send_pct = 37;
		stall_pct = 74;
		nv_reg = 1;
		lf_reg = 1;
		lc_reg = 20;
		step_cnt = 0;
		foreach (mean_val[i]) mean_val[i] = 0;
		samples.valid = 1'b0;
		samples.var_index = '0;
		samples.sample = '0;
		samples.last_sample = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_NUM_VARS;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{0, REG_NUM_VARS, 0, 2'd0, 32'd5, 1, 1});
		rows.push_back('{1, REG_NUM_VARS, 12'd2, 0, 0, 0, 0});
		rows.push_back('{1, REG_LAG_FIRST, 12'd0, 0, 0, 0, 0});
		rows.push_back('{1, REG_LAG_COUNT, 12'd3, 0, 0, 0, 0});
		rows.push_back('{0, REG_NUM_VARS, 0, 2'd0, 32'h7FFFFFFF, 0, 0});
		rows.push_back('{0, REG_NUM_VARS, 0, 2'd1, 32'h80000000, 0, 0});
		rows.push_back('{0, REG_NUM_VARS, 0, 2'd0, 32'h80000000, 0, 0});
		rows.push_back('{0, REG_NUM_VARS, 0, 2'd1, 32'h7FFFFFFF, 0, 0});
		rows.push_back('{0, REG_NUM_VARS, 0, 2'd3, 32'd123, 0, 0});
		rows.push_back('{0, REG_NUM_VARS, 0, 2'd0, 32'h00010000, 0, 0});
		rows.push_back('{0, REG_NUM_VARS, 0, 2'd1, 32'hFFFF0000, 1, 0});
		rows.push_back('{1, REG_NUM_VARS, 12'd0, 0, 0, 0, 0});
		rows.push_back('{1, REG_LAG_FIRST, 12'd4095, 0, 0, 0, 0});
		rows.push_back('{1, REG_LAG_COUNT, 12'd0, 0, 0, 0, 0});
		rows.push_back('{0, REG_NUM_VARS, 0, 2'd0, 32'h00010000, 0, 0});
		rows.push_back('{0, REG_NUM_VARS, 0, 2'd0, 32'h00030000, 1, 0});
		rows.push_back('{1, REG_NUM_VARS, 12'd7, 0, 0, 0, 0});
		rows.push_back('{1, REG_LAG_FIRST, 12'd1, 0, 0, 0, 0});
		rows.push_back('{1, REG_LAG_COUNT, 12'd127, 0, 0, 0, 0});
		for (int i = 0; i < 8; i++)
			rows.push_back('{0, REG_NUM_VARS, 0, 2'(i % 4), 32'(i * 40000 - 150000), 0, 0});
		rows.push_back('{0, REG_NUM_VARS, 0, 2'd0, 32'd77, 1, 0});
		rows.push_back('{1, REG_NUM_VARS, 12'd1, 0, 0, 0, 0});
		rows.push_back('{0, REG_NUM_VARS, 0, 2'd2, 32'd9, 1, 1});

		foreach (rows[i]) begin
			if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].data);
			else send_sample(rows[i].vi, rows[i].smp, rows[i].last, rows[i].zero_run);
		end

		while (items_sent < 360) begin
			if (items_sent >= 120) begin
				send_pct = 74;
				stall_pct = 37;
			end
			if (items_sent >= 240) begin
				send_pct = 0;
				stall_pct = 0;
			end
			steps = $urandom_range(9) == 0 ? $urandom_range(60) : $urandom_range(1, 24);
			write_reg(REG_NUM_VARS, CFG_DW'($urandom_range(9) == 0 ? $urandom_range(7) :
				$urandom_range(1, 4)));
			write_reg(REG_LAG_FIRST, CFG_DW'($urandom_range(7) == 0 ? $urandom_range(4095) :
				$urandom_range(steps + 2)));
			write_reg(REG_LAG_COUNT, CFG_DW'($urandom_range(9) == 0 ? $urandom_range(127) :
				$urandom_range(1, 12)));
			nv = eff_vars();
			base = $urandom;
			flat = $urandom_range(7) == 0;
			for (int unsigned s = 0; s < steps; s++)
				for (int unsigned v = 0; v < nv; v++) begin
					if (nv < MAX_VARS_DEF && $urandom_range(19) == 0) begin
						vi = 2'($urandom_range(3, nv));
						send_sample(vi, $urandom, 1'b0, 1'b0);
					end
					send_sample(2'(v), flat ? base : pick_value(base),
						s == steps - 1 && v == nv - 1 && $urandom_range(5) != 0, 1'b0);
				end
			if (step_cnt != 0 || steps == 0 || items_sent == 0 || acf_expected.size() == 0) begin
				if ($urandom_range(1) || nv == MAX_VARS_DEF)
					send_sample(2'd0, pick_value(base), 1'b1, 1'b0);
				else begin
					vi = 2'($urandom_range(3, nv));
					send_sample(vi, $urandom, 1'b1, 1'b0);
				end
			end
		end

		samples.valid <= 1'b0;
		while (acf_expected.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && acf_expected.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
